// ===== hdl/ip6csum_pkg.sv =====
// Shared constants, types and a ones'-complement helper for the IPv6 transport checksum unit.
`timescale 1ns / 1ps

package ip6csum_pkg;

   localparam int unsigned COUNT_WIDTH = 17;
   localparam int unsigned WORD_WIDTH  = 16;

   localparam logic [7:0] PROTO_UDP   = 8'd17;
   localparam logic [7:0] PROTO_ICMP6 = 8'd58;

   localparam logic [COUNT_WIDTH-1:0] IP6_HDR_LEN    = 17'd40;
   localparam logic [COUNT_WIDTH-1:0] POS_NEXT_HDR   = 17'd6;
   localparam logic [COUNT_WIDTH-1:0] POS_FIRST_ADDR = 17'd8;
   localparam logic [COUNT_WIDTH-1:0] POS_ADDR_WORD  = 17'd9;
   localparam logic [COUNT_WIDTH-1:0] POS_ICMP_CSUM  = 17'd42;
   localparam logic [COUNT_WIDTH-1:0] POS_UDP_LEN_HI = 17'd44;
   localparam logic [COUNT_WIDTH-1:0] POS_UDP_LEN_LO = 17'd45;
   localparam logic [COUNT_WIDTH-1:0] POS_UDP_CSUM   = 17'd46;
   localparam logic [COUNT_WIDTH-1:0] UDP_MIN_LEN    = 17'd48;
   localparam logic [COUNT_WIDTH-1:0] ICMP_MIN_LEN   = 17'd44;
   localparam logic [COUNT_WIDTH-1:0] COUNT_CEILING  = 17'h1FFFE;

   localparam logic [WORD_WIDTH-1:0] ALL_ONES = 16'hFFFF;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_PROTO = 2'd1,
      STATUS_SHORT     = 2'd2
   } status_type;

   typedef struct packed {
      status_type             status;
      logic [WORD_WIDTH-1:0]  fill_checksum;
      logic                   checksum_ok;
   } result_type;

   // Ones'-complement add of two 16-bit values with end-around carry.
   function automatic logic [WORD_WIDTH-1:0] oc_add(input logic [WORD_WIDTH-1:0] a,
                                                    input logic [WORD_WIDTH-1:0] b);
      logic [WORD_WIDTH:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[WORD_WIDTH-1:0] + {{(WORD_WIDTH-1){1'b0}}, s[WORD_WIDTH]};
   endfunction

endpackage

// ===== hdl/ipv6_transport_checksum_check_fill_unit.sv =====
// Top level of the IPv6 transport checksum checker and filler.
`timescale 1ns / 1ps

// The unit takes an IPv6 packet as a stream of byte words, starting at byte 0 of the IPv6
// header, with tlast on the final byte. It reads the next-header byte, accepts UDP or ICMPv6,
// and forms the internet checksum over the pseudo-header (source and destination addresses,
// transport length, protocol) and the transport bytes, an odd final byte being padded with a
// zero low byte. The transport length is the UDP length field for UDP and the number of bytes
// after the 40-byte IPv6 header for ICMPv6. On the last byte of each packet it delivers one
// result word: whether the received checksum verifies, the value that belongs in the checksum
// field (computed with that field taken as zero), and a status. For UDP a received checksum
// of zero never verifies and a computed zero is sent as 0xFFFF. A packet with another next
// header gives status 1; one that ends before its checksum field gives status 2; both carry
// checksum_ok and fill_checksum as zero. One byte is accepted in every clock cycle unless a
// last byte waits on a full output register: each byte passes through an input register and
// is added into the running sum, and the result of the last byte is written into an output
// register. A result waiting in the output register does not stop the input; only a further
// last byte waits until it has been taken. All running state returns to zero after every
// packet, so packets follow one another with no gap.
module ipv6_transport_checksum_check_fill_unit
   import ip6csum_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Packet byte stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_byte
   // Result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // [0] checksum_ok, [16:1] fill_checksum, [18:17] status,
                                    // [23:19] zero
);

   // Input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_data_ff;
   logic       in_last_ff;

   // Per-packet running state
   logic [COUNT_WIDTH-1:0] byte_count_ff, byte_count_in;
   logic [WORD_WIDTH-1:0]  sum_acc_ff, sum_acc_in;
   logic [7:0]             high_byte_ff, high_byte_in;
   logic [7:0]             next_header_ff, next_header_in;
   logic [WORD_WIDTH-1:0]  rx_csum_ff, rx_csum_in;
   logic [WORD_WIDTH-1:0]  udp_len_ff, udp_len_in;

   // Output register
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff, rsp_data_in;

   // Datapath signals
   logic                   advance;
   logic                   load_result;
   logic [COUNT_WIDTH-1:0] cnt;
   logic [COUNT_WIDTH-1:0] total;
   logic [WORD_WIDTH-1:0]  word;
   logic                   is_csum;
   logic                   add_word;
   logic                   add_pad;
   logic                   is_udp;
   logic                   is_icmp;
   logic [COUNT_WIDTH-1:0] length;
   logic [18:0]            wide_sum;
   logic [16:0]            fold_one;
   logic [WORD_WIDTH-1:0]  fsum;
   logic [WORD_WIDTH-1:0]  vsum;
   logic                   ok;
   result_type             result;

   // A buffered byte moves on unless it closes a packet and the output register is still full.
   assign advance     = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || advance;
   assign load_result = advance && in_last_ff;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !advance);

   assign cnt = byte_count_ff;

   always_comb begin
      byte_count_in  = byte_count_ff;
      sum_acc_in     = sum_acc_ff;
      high_byte_in   = high_byte_ff;
      next_header_in = next_header_ff;
      rx_csum_in     = rx_csum_ff;
      udp_len_in     = udp_len_ff;
      total          = cnt + 17'd1;
      word           = {high_byte_ff, in_data_ff};
      is_csum        = 1'b0;
      add_word       = 1'b0;
      add_pad        = 1'b0;
      is_udp         = 1'b0;
      is_icmp        = 1'b0;
      length         = '0;
      wide_sum       = '0;
      fold_one       = '0;
      fsum           = '0;
      vsum           = '0;
      ok             = 1'b0;
      result         = '{status: STATUS_OK, fill_checksum: '0, checksum_ok: 1'b0};

      if (cnt == POS_NEXT_HDR) begin
         next_header_in = in_data_ff;
      end
      if (cnt == POS_UDP_LEN_HI) begin
         udp_len_in = {in_data_ff, udp_len_ff[7:0]};
      end
      if (cnt == POS_UDP_LEN_LO) begin
         udp_len_in = {udp_len_ff[15:8], in_data_ff};
      end

      // Even offsets hold the high byte; odd offsets from the source address on close a word.
      if (!cnt[0]) begin
         high_byte_in = in_data_ff;
      end else if (cnt >= POS_ADDR_WORD) begin
         is_csum = ((next_header_ff == PROTO_UDP)   && (cnt - 17'd1 == POS_UDP_CSUM)) ||
                   ((next_header_ff == PROTO_ICMP6) && (cnt - 17'd1 == POS_ICMP_CSUM));
         if (is_csum) begin
            rx_csum_in = word;
         end else begin
            add_word   = 1'b1;
            sum_acc_in = oc_add(sum_acc_ff, word);
         end
      end

      // At and past the ceiling the count toggles its lowest bit so that byte pairing stays right.
      if (cnt >= COUNT_CEILING) begin
         total = cnt ^ 17'd1;
      end
      byte_count_in = total;

      // Closing arithmetic: all terms go into one wide sum, folded twice to 16 bits.
      add_pad = !cnt[0] && (cnt >= POS_FIRST_ADDR);
      is_udp  = (next_header_in == PROTO_UDP);
      is_icmp = (next_header_in == PROTO_ICMP6);
      length  = is_udp ? {1'b0, udp_len_in} : (total - IP6_HDR_LEN);

      wide_sum = {3'b000, sum_acc_ff}
               + (add_word ? {3'b000, word} : 19'd0)
               + (add_pad  ? {3'b000, in_data_ff, 8'h00} : 19'd0)
               + {18'd0, length[16]}
               + {3'b000, length[15:0]}
               + {11'd0, next_header_in};
      fold_one = {1'b0, wide_sum[15:0]} + {14'd0, wide_sum[18:16]};
      fsum     = fold_one[15:0] + {15'd0, fold_one[16]};
      vsum     = oc_add(fsum, rx_csum_in);
      ok       = (vsum == ALL_ONES);

      if (is_udp) begin
         if (rx_csum_in == '0) begin
            ok = 1'b0;
         end
         if (fsum == ALL_ONES) begin
            fsum = '0;
         end
      end

      if (cnt < POS_NEXT_HDR) begin
         result.status = STATUS_SHORT;
      end else if (!is_udp && !is_icmp) begin
         result.status = STATUS_BAD_PROTO;
      end else if ((is_udp && total < UDP_MIN_LEN) || (is_icmp && total < ICMP_MIN_LEN)) begin
         result.status = STATUS_SHORT;
      end else begin
         result.status        = STATUS_OK;
         result.checksum_ok   = ok;
         result.fill_checksum = ~fsum;
      end

      // Every packet starts from cleared state.
      if (in_last_ff) begin
         byte_count_in  = '0;
         sum_acc_in     = '0;
         high_byte_in   = '0;
         next_header_in = '0;
         rx_csum_in     = '0;
         udp_len_in     = '0;
      end
   end

   assign rsp_valid_in = load_result || (rsp_valid_ff && !rsp_tready);
   assign rsp_data_in  = load_result ? result : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         byte_count_ff  <= '0;
         sum_acc_ff     <= '0;
         high_byte_ff   <= '0;
         next_header_ff <= '0;
         rx_csum_ff     <= '0;
         udp_len_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            byte_count_ff  <= byte_count_in;
            sum_acc_ff     <= sum_acc_in;
            high_byte_ff   <= high_byte_in;
            next_header_ff <= next_header_in;
            rx_csum_ff     <= rx_csum_in;
            udp_len_ff     <= udp_len_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_data_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b00000, rsp_data_ff};

endmodule
